[rtl/lcer_pkg.sv]
package lcer_pkg;

    // Field widths
    localparam int COORD_W = 10;
    localparam int ERR_W   = 12;
    localparam int COL_W   = 11;

    // Default store depth
    localparam int COLUMNS_DEF = 1024;

    // Marks an empty last-column register
    localparam logic [COL_W-1:0] NO_COLUMN = '1;

    // Request kinds
    localparam logic REQ_DRAW = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Reply kinds
    localparam logic REPLY_ACK  = 1'b0;
    localparam logic REPLY_READ = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load_draw;   // latch line end points, init walk
        logic load_read;   // launch column store read
        logic step;        // plot current point and advance
        logic load_out;    // capture reply into output register
    } lcer_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic at_end;      // walk position equals line end point
    } lcer_sts_t;

endpackage

[rtl/lcer_req_if.sv]
interface lcer_req_if;
    import lcer_pkg::*;

    logic               valid;
    logic               ready;
    logic               req_type;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
    logic               keep_top;
    logic [COORD_W-1:0] read_column;

    modport source (
        output valid, req_type, x_start, y_start, x_end, y_end, keep_top, read_column,
        input  ready
    );

    modport sink (
        input  valid, req_type, x_start, y_start, x_end, y_end, keep_top, read_column,
        output ready
    );

endinterface

[rtl/lcer_rsp_if.sv]
interface lcer_rsp_if;
    import lcer_pkg::*;

    logic               valid;
    logic               ready;
    logic               reply_kind;
    logic [COORD_W-1:0] column_y;

    modport source (
        output valid, reply_kind, column_y,
        input  ready
    );

    modport sink (
        input  valid, reply_kind, column_y,
        output ready
    );

endinterface

[rtl/lcer_ctrl.sv]
module lcer_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_type,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output lcer_pkg::lcer_cmd_t cmd,
    input  lcer_pkg::lcer_sts_t sts
);
    import lcer_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_REPLY = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_fire;
    logic   slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_type == REQ_DRAW)
                    begin
                        cmd.load_draw = 1'b1;
                        state_next    = ST_WALK;
                    end
                    else
                    begin
                        cmd.load_read = 1'b1;
                        state_next    = ST_REPLY;
                    end
                end
            end
            ST_WALK:
            begin
                cmd.step = 1'b1;
                if (sts.at_end)
                begin
                    state_next = ST_REPLY;
                end
            end
            ST_REPLY:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // An accepted item always leaves idle
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start processing");

    // A new reply only comes from the reply state
    a_reply_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_REPLY))
        else $error("reply raised outside reply state");

endmodule

[rtl/lcer_dpath.sv]
module lcer_dpath #(
    parameter int COLUMNS = lcer_pkg::COLUMNS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lcer_pkg::lcer_cmd_t          cmd,
    output lcer_pkg::lcer_sts_t          sts,
    input  logic                         req_type,
    input  logic [lcer_pkg::COORD_W-1:0] x_start,
    input  logic [lcer_pkg::COORD_W-1:0] y_start,
    input  logic [lcer_pkg::COORD_W-1:0] x_end,
    input  logic [lcer_pkg::COORD_W-1:0] y_end,
    input  logic                         keep_top,
    input  logic [lcer_pkg::COORD_W-1:0] read_column,
    output logic                         reply_kind,
    output logic [lcer_pkg::COORD_W-1:0] column_y
);
    import lcer_pkg::*;

    localparam int ADDR_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    // Walk registers
    logic [COORD_W-1:0]       cur_x_reg, cur_x_next;
    logic [COORD_W-1:0]       cur_y_reg, cur_y_next;
    logic [COORD_W-1:0]       end_x_reg, end_y_reg;
    logic [COORD_W-1:0]       dx_reg, dy_reg;
    logic                     xinc_reg, yinc_reg, top_reg;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic [COL_W-1:0]         last_col_reg;
    logic [COORD_W-1:0]       last_y_reg;
    logic                     kind_reg;
    logic                     read_ok_reg;

    // Output payload
    logic                     out_kind_reg;
    logic [COORD_W-1:0]       out_y_reg;

    // Column store
    logic [COORD_W-1:0]       mem [COLUMNS];
    logic [COORD_W-1:0]       rd_data_reg;
    logic                     mem_we;
    logic [ADDR_W-1:0]        waddr;
    logic [ADDR_W-1:0]        raddr;

    // Step logic
    logic [COORD_W-1:0]       dx_in, dy_in;
    logic signed [ERR_W:0]    e2;
    logic signed [ERR_W:0]    dx_ext, dy_ext;
    logic signed [ERR_W-1:0]  dx_err, dy_err;
    logic                     x_go, y_go, hit, y_take;
    logic [COORD_W-1:0]       nx, ny;
    logic                     x_in_range, take, le;

    // Absolute deltas at load
    assign dx_in = (x_end >= x_start) ? (x_end - x_start) : (x_start - x_end);
    assign dy_in = (y_end >= y_start) ? (y_end - y_start) : (y_start - y_end);

    assign sts.at_end = (cur_x_reg == end_x_reg) && (cur_y_reg == end_y_reg);

    // Error term decisions
    assign e2     = {err_reg, 1'b0};
    assign dx_ext = $signed({{(ERR_W+1-COORD_W){1'b0}}, dx_reg});
    assign dy_ext = $signed({{(ERR_W+1-COORD_W){1'b0}}, dy_reg});
    assign dx_err = $signed({{(ERR_W-COORD_W){1'b0}}, dx_reg});
    assign dy_err = $signed({{(ERR_W-COORD_W){1'b0}}, dy_reg});
    assign x_go   = e2 > -dy_ext;
    assign y_go   = e2 < dx_ext;

    // X step, then end test before the y step
    assign nx     = x_go ? (xinc_reg ? cur_x_reg + 1'b1 : cur_x_reg - 1'b1) : cur_x_reg;
    assign hit    = (nx == end_x_reg) && (cur_y_reg == end_y_reg);
    assign y_take = y_go && !hit;
    assign ny     = y_take ? (yinc_reg ? cur_y_reg + 1'b1 : cur_y_reg - 1'b1) : cur_y_reg;

    // Plot: first point in a column always writes, later ones keep the extreme
    assign x_in_range = 32'(cur_x_reg) < COLUMNS;
    assign le         = last_y_reg <= cur_y_reg;
    assign take       = (last_col_reg != {1'b0, cur_x_reg}) || (top_reg ? !le : le);
    assign mem_we     = cmd.step && x_in_range && take;
    assign waddr      = ADDR_W'(cur_x_reg);
    assign raddr      = ADDR_W'(read_column);

    always_comb
    begin
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        err_next   = err_reg;
        if (cmd.load_draw)
        begin
            cur_x_next = x_start;
            cur_y_next = y_start;
            err_next   = $signed({{(ERR_W-COORD_W){1'b0}}, dx_in})
                       - $signed({{(ERR_W-COORD_W){1'b0}}, dy_in});
        end
        else if (cmd.step && !sts.at_end)
        begin
            cur_x_next = nx;
            cur_y_next = ny;
            err_next   = err_reg - (x_go ? dy_err : '0) + (y_take ? dx_err : '0);
        end
    end

    // Control-like walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            err_reg      <= '0;
            last_col_reg <= NO_COLUMN;
        end
        else
        begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            err_reg   <= err_next;
            if (cmd.load_draw)
            begin
                last_col_reg <= NO_COLUMN;
            end
            else if (mem_we)
            begin
                last_col_reg <= {1'b0, cur_x_reg};
            end
        end
    end

    // Request payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_draw || cmd.load_read)
        begin
            kind_reg <= req_type;
        end
        if (cmd.load_draw)
        begin
            end_x_reg <= x_end;
            end_y_reg <= y_end;
            dx_reg    <= dx_in;
            dy_reg    <= dy_in;
            xinc_reg  <= x_start < x_end;
            yinc_reg  <= y_start < y_end;
            top_reg   <= keep_top;
        end
        if (cmd.load_read)
        begin
            read_ok_reg <= 32'(read_column) < COLUMNS;
        end
        if (mem_we)
        begin
            last_y_reg <= cur_y_reg;
        end
        if (cmd.load_out)
        begin
            out_kind_reg <= kind_reg;
            out_y_reg    <= (kind_reg == REQ_READ && read_ok_reg) ? rd_data_reg : '0;
        end
    end

    // Column store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= cur_y_reg;
        end
        if (cmd.load_read)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign reply_kind = out_kind_reg;
    assign column_y   = out_y_reg;

    // Every step short of the end moves the walk
    a_walk_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && !sts.at_end) |=>
            ((cur_x_reg != $past(cur_x_reg)) || (cur_y_reg != $past(cur_y_reg))))
        else $error("walk step made no progress");

    // A new line starts with no column claimed
    a_draw_clears_column: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_draw |=> (last_col_reg == NO_COLUMN))
        else $error("last column not cleared at line start");

endmodule

[rtl/line_column_extent_rasterizer.sv]
// Draw item: accept, walk and plot the line points (max(dx,dy)+1, up to 1024),
//   then load the reply register.
// Read item: accept, a registered column store read, then the reply.
// One item is in work at a time; the next is taken while the reply waits to be taken.
// Reset clears the controller, walk position and reply valid; the column store is
//   not cleared and holds undefined values until written.
module line_column_extent_rasterizer #(
    parameter int COLUMNS = lcer_pkg::COLUMNS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    lcer_req_if.sink   req,
    lcer_rsp_if.source rsp
);
    import lcer_pkg::*;

    lcer_cmd_t cmd;
    lcer_sts_t sts;

    lcer_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_type   (req.req_type),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    lcer_dpath #(
        .COLUMNS (COLUMNS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_type    (req.req_type),
        .x_start     (req.x_start),
        .y_start     (req.y_start),
        .x_end       (req.x_end),
        .y_end       (req.y_end),
        .keep_top    (req.keep_top),
        .read_column (req.read_column),
        .reply_kind  (rsp.reply_kind),
        .column_y    (rsp.column_y)
    );

endmodule

[tb/tb_line_column_extent_rasterizer.sv]
module tb_line_column_extent_rasterizer;
    import lcer_pkg::*;

    localparam int COLUMNS      = COLUMNS_DEF;
    localparam int WALK_LIMIT   = 2050;
    localparam int RANDOM_ITEMS = 267;
    localparam int DRAIN_CYCLES = 1100;
    localparam int RUN_LIMIT    = 20_000_000;

    // Handshake pressure phases
    typedef enum int {
        PH_RX_SLOW = 0,
        PH_TX_SLOW = 1,
        PH_NO_IDLE = 2
    } idle_phase_t;

    typedef struct {
        logic               req_type;
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
        logic               keep_top;
        logic [COORD_W-1:0] read_column;
        idle_phase_t        phase;
    } raster_req_t;

    typedef struct {
        logic               reply_kind;
        logic [COORD_W-1:0] column_y;
    } raster_reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lcer_req_if req();
    lcer_rsp_if rsp();

    line_column_extent_rasterizer #(
        .COLUMNS(COLUMNS)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    always #5 clk = ~clk;

    raster_req_t   pending_requests[$];
    raster_reply_t expected_replies[$];
    raster_req_t   driven_req;
    idle_phase_t   cur_phase;
    int            accepted_cnt;
    int            replies_cnt;
    int            mismatch_cnt = 0;

    // Shadow of the block state
    logic [COORD_W-1:0]        shadow_extent[COLUMNS];
    logic [COORD_W-1:0]        walk_x;
    logic [COORD_W-1:0]        walk_y;
    logic signed [ERR_W-1:0]   walk_err;
    logic [COL_W-1:0]          shadow_last_col;

    // Stimulus bookkeeping: columns known to hold a value
    bit column_written[COLUMNS];
    int span_lo;
    int span_hi;

    function automatic int tx_idle_pct(idle_phase_t ph);
        case (ph)
            PH_RX_SLOW: return 18;
            PH_TX_SLOW: return 65;
            default:    return 0;
        endcase
    endfunction

    function automatic int rx_idle_pct(idle_phase_t ph);
        case (ph)
            PH_RX_SLOW: return 65;
            PH_TX_SLOW: return 18;
            default:    return 0;
        endcase
    endfunction

    // Write one line point into the column store
    function automatic void plot_column(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                        logic top);
        logic take;
        logic le;
        if (int'(x) >= COLUMNS)
            return;
        if (shadow_last_col != {1'b0, x})
            take = 1'b1;
        else
        begin
            le   = shadow_extent[x] <= y;
            take = top ? !le : le;
        end
        if (take)
        begin
            shadow_extent[x] = y;
            shadow_last_col  = {1'b0, x};
        end
    endfunction

    // Walk a line or look up a column, return the reply it produces
    function automatic raster_reply_t rasterize_request(raster_req_t r);
        raster_reply_t rep;
        int   dx;
        int   dy;
        int   e2;
        logic xinc;
        logic yinc;
        rep.reply_kind = REPLY_ACK;
        rep.column_y   = '0;
        if (r.req_type == REQ_DRAW)
        begin
            dx   = (r.x_end >= r.x_start) ? int'(r.x_end) - int'(r.x_start)
                                          : int'(r.x_start) - int'(r.x_end);
            dy   = (r.y_end >= r.y_start) ? int'(r.y_end) - int'(r.y_start)
                                          : int'(r.y_start) - int'(r.y_end);
            xinc = r.x_start < r.x_end;
            yinc = r.y_start < r.y_end;
            walk_x          = r.x_start;
            walk_y          = r.y_start;
            walk_err        = ERR_W'(dx - dy);
            shadow_last_col = NO_COLUMN;
            for (int guard = 0; guard < WALK_LIMIT; guard++)
            begin
                plot_column(walk_x, walk_y, r.keep_top);
                if (walk_x == r.x_end && walk_y == r.y_end)
                    break;
                e2 = 2 * int'(walk_err);
                if (e2 > -dy)
                begin
                    walk_err = ERR_W'(int'(walk_err) - dy);
                    walk_x   = xinc ? walk_x + 1'b1 : walk_x - 1'b1;
                end
                // end may be hit right after the x step
                if (walk_x == r.x_end && walk_y == r.y_end)
                begin
                    plot_column(walk_x, walk_y, r.keep_top);
                    break;
                end
                if (e2 < dx)
                begin
                    walk_err = ERR_W'(int'(walk_err) + dx);
                    walk_y   = yinc ? walk_y + 1'b1 : walk_y - 1'b1;
                end
            end
        end
        else
        begin
            rep.reply_kind = REPLY_READ;
            rep.column_y   = (int'(r.read_column) < COLUMNS) ? shadow_extent[r.read_column]
                                                             : '0;
        end
        return rep;
    endfunction

    function automatic logic [COORD_W-1:0] fit_coord(int v);
        if (v < 0)
            return '0;
        if (v > 1023)
            return '1;
        return COORD_W'(v);
    endfunction

    task automatic push_draw(int x0, int y0, int x1, int y1, logic top, idle_phase_t ph);
        raster_req_t r;
        r.req_type    = REQ_DRAW;
        r.x_start     = fit_coord(x0);
        r.y_start     = fit_coord(y0);
        r.x_end       = fit_coord(x1);
        r.y_end       = fit_coord(y1);
        r.keep_top    = top;
        r.read_column = COORD_W'($urandom_range(1023));
        r.phase       = ph;
        pending_requests.push_back(r);
        // every column between the ends gets visited
        span_lo = (r.x_start < r.x_end) ? int'(r.x_start) : int'(r.x_end);
        span_hi = (r.x_start < r.x_end) ? int'(r.x_end) : int'(r.x_start);
        for (int c = span_lo; c <= span_hi; c++)
            column_written[c] = 1'b1;
    endtask

    task automatic push_read(int col, idle_phase_t ph);
        raster_req_t r;
        r.req_type    = REQ_READ;
        r.x_start     = COORD_W'($urandom_range(1023));
        r.y_start     = COORD_W'($urandom_range(1023));
        r.x_end       = COORD_W'($urandom_range(1023));
        r.y_end       = COORD_W'($urandom_range(1023));
        r.keep_top    = 1'($urandom_range(1));
        r.read_column = fit_coord(col);
        r.phase       = ph;
        pending_requests.push_back(r);
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        logic took;
        if (!rst_n)
        begin
            req.valid       <= 1'b0;
            req.req_type    <= REQ_DRAW;
            req.x_start     <= '0;
            req.y_start     <= '0;
            req.x_end       <= '0;
            req.y_end       <= '0;
            req.keep_top    <= 1'b0;
            req.read_column <= '0;
            cur_phase       <= PH_RX_SLOW;
            accepted_cnt    <= 0;
        end
        else
        begin
            took = req.valid && req.ready;
            if (took)
            begin
                expected_replies.push_back(rasterize_request(driven_req));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!req.valid || took)
            begin
                if (pending_requests.size() == 0)
                    req.valid <= 1'b0;
                else if (pending_requests[0].phase != cur_phase)
                begin
                    // hold off until every outstanding reply is back
                    req.valid <= 1'b0;
                    if (!took && accepted_cnt == replies_cnt)
                        cur_phase <= pending_requests[0].phase;
                end
                else if ($urandom_range(99) < tx_idle_pct(cur_phase))
                    req.valid <= 1'b0;
                else
                begin
                    driven_req       = pending_requests.pop_front();
                    req.valid       <= 1'b1;
                    req.req_type    <= driven_req.req_type;
                    req.x_start     <= driven_req.x_start;
                    req.y_start     <= driven_req.y_start;
                    req.x_end       <= driven_req.x_end;
                    req.y_end       <= driven_req.y_end;
                    req.keep_top    <= driven_req.keep_top;
                    req.read_column <= driven_req.read_column;
                end
            end
        end
    end

    // Reply monitor and checker
    always @(posedge clk or negedge rst_n)
    begin : check_replies
        raster_reply_t want;
        if (!rst_n)
        begin
            rsp.ready   <= 1'b0;
            replies_cnt <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                replies_cnt <= replies_cnt + 1;
                if (expected_replies.size() == 0)
                begin
                    $display("%0t: unexpected reply: expected none, got kind %0d y %0d",
                             $time, rsp.reply_kind, rsp.column_y);
                    mismatch_cnt++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (rsp.reply_kind !== want.reply_kind)
                    begin
                        $display("%0t: reply_kind mismatch: expected %0d, got %0d",
                                 $time, want.reply_kind, rsp.reply_kind);
                        mismatch_cnt++;
                    end
                    if (rsp.column_y !== want.column_y)
                    begin
                        $display("%0t: column_y mismatch: expected %0d, got %0d",
                                 $time, want.column_y, rsp.column_y);
                        mismatch_cnt++;
                    end
                end
            end
            rsp.ready <= ($urandom_range(99) >= rx_idle_pct(cur_phase));
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int          x0;
        int          y0;
        int          x1;
        int          y1;
        int          dxs;
        int          dys;
        int          col;
        int          last_x0;
        idle_phase_t ph;

        // Directed: full diagonals, corners, degenerate, vertical, horizontal, steep
        push_draw(0, 0, 1023, 1023, 1'b0, PH_RX_SLOW);
        push_read(0, PH_RX_SLOW);
        push_read(1023, PH_RX_SLOW);
        push_read(512, PH_RX_SLOW);
        push_draw(1023, 0, 0, 1023, 1'b1, PH_RX_SLOW);
        push_read(1023, PH_RX_SLOW);
        push_read(0, PH_RX_SLOW);
        push_draw(7, 300, 7, 300, 1'b0, PH_RX_SLOW);
        push_read(7, PH_RX_SLOW);
        push_draw(7, 0, 7, 1023, 1'b0, PH_RX_SLOW);
        push_read(7, PH_RX_SLOW);
        push_draw(7, 1023, 7, 0, 1'b1, PH_RX_SLOW);
        push_read(7, PH_RX_SLOW);
        push_draw(110, 1023, 100, 1023, 1'b1, PH_RX_SLOW);
        push_read(105, PH_RX_SLOW);
        push_draw(20, 10, 23, 900, 1'b0, PH_RX_SLOW);
        push_read(21, PH_RX_SLOW);
        push_draw(23, 900, 20, 10, 1'b1, PH_RX_SLOW);
        push_read(22, PH_RX_SLOW);
        push_draw(30, 30, 40, 32, 1'b0, PH_RX_SLOW);
        push_read(35, PH_RX_SLOW);
        push_draw(41, 33, 40, 32, 1'b1, PH_RX_SLOW);
        push_read(40, PH_RX_SLOW);

        // Random: mostly short lines, a few long ones, reads of visited columns
        last_x0 = 512;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            ph = idle_phase_t'((n * 3) / RANDOM_ITEMS);
            if ($urandom_range(99) < 45)
            begin
                if ($urandom_range(99) < 30)
                    x0 = int'(fit_coord(last_x0 + int'($urandom_range(16)) - 8));
                else
                    x0 = $urandom_range(1023);
                y0 = $urandom_range(1023);
                if ($urandom_range(99) < 8)
                begin
                    dxs = $urandom_range(1023);
                    dys = $urandom_range(1023);
                end
                else
                begin
                    dxs = $urandom_range(24);
                    dys = $urandom_range(40);
                end
                x1 = $urandom_range(1) ? x0 + dxs : x0 - dxs;
                y1 = $urandom_range(1) ? y0 + dys : y0 - dys;
                push_draw(x0, y0, x1, y1, 1'($urandom_range(1)), ph);
                last_x0 = x0;
            end
            else
            begin
                if ($urandom_range(99) < 60)
                    col = span_lo + int'($urandom_range(span_hi - span_lo));
                else
                begin
                    col = $urandom_range(1023);
                    while (!column_written[col])
                        col = $urandom_range(1023);
                end
                push_read(col, ph);
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || req.valid || accepted_cnt != replies_cnt)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0 && expected_replies.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Run time limit
    initial
    begin
        #(RUN_LIMIT);
        $display("simulation failed");
        $finish;
    end

endmodule
